@@ rtl/lcnt_pkg.sv @@
package lcnt_pkg;

  localparam int CFG_W     = 7;
  localparam int ROW_W     = 6;
  localparam int COL_W     = 6;
  localparam int COUNT_W   = 4;
  localparam int TAP_IDX_W = 4;

  // Register indexes of the configuration port
  localparam logic [1:0] CFG_ROWS = 2'd0;
  localparam logic [1:0] CFG_COLS = 2'd1;

  localparam logic [CFG_W-1:0] MIN_SIZE = 7'd3;

  localparam logic [0:0] MODE_WRITE = 1'b0;
  localparam logic [0:0] MODE_QUERY = 1'b1;

  // Nine taps of the 3x3 window, scanned row by row; the middle one is the cell
  localparam logic [TAP_IDX_W-1:0] TAP_FIRST  = 4'd0;
  localparam logic [TAP_IDX_W-1:0] TAP_CENTER = 4'd4;
  localparam logic [TAP_IDX_W-1:0] TAP_LAST   = 4'd8;

  localparam logic [COUNT_W-1:0] COUNT_TWO   = 4'd2;
  localparam logic [COUNT_W-1:0] COUNT_THREE = 4'd3;

  typedef struct packed {
    logic [0:0]       mode;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             alive_in;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] neighbour_count;
    logic               next_alive;
    logic               flips;
  } out_item_t;

  typedef struct packed {
    logic                 wr_en;
    logic                 start;
    logic                 rd_en;
    logic [TAP_IDX_W-1:0] rd_idx;
    logic                 load_out;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

@@ rtl/lcnt_ctrl.sv @@
module lcnt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [0:0]          in_mode,
  output logic                in_ready,
  input  lcnt_pkg::stat_t     stat,
  output lcnt_pkg::cmd_t      cmd
);
  import lcnt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_DONE
  } state_t;

  state_t               state;
  logic [TAP_IDX_W-1:0] tap;
  logic                 accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd          = '0;
    cmd.wr_en    = accept && (in_mode == MODE_WRITE);
    cmd.start    = accept && (in_mode == MODE_QUERY);
    cmd.rd_en    = (state == ST_READ);
    cmd.rd_idx   = tap;
    cmd.load_out = (state == ST_DONE) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      tap   <= TAP_FIRST;
    end else begin
      case (state)
        ST_IDLE: begin
          tap <= TAP_FIRST;
          if (cmd.start) state <= ST_READ;
        end
        ST_READ: begin
          if (tap == TAP_LAST) state <= ST_DRAIN;
          else tap <= tap + 4'd1;
        end
        ST_DRAIN: state <= ST_DONE;
        ST_DONE: begin
          if (stat.out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/lcnt_dp.sv @@
module lcnt_dp #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  lcnt_pkg::cmd_t              cmd,
  output lcnt_pkg::stat_t             stat,
  input  lcnt_pkg::in_item_t          in_data,
  input  logic [lcnt_pkg::CFG_W-1:0]  rows_cfg,
  input  logic [lcnt_pkg::CFG_W-1:0]  cols_cfg,
  output logic                        out_valid,
  input  logic                        out_ready,
  output lcnt_pkg::out_item_t         out_data
);
  import lcnt_pkg::*;

  localparam int RAW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CAW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int DEPTH = 1 << (RAW + CAW);

  logic mem [0:DEPTH-1];

  logic [CFG_W-1:0]     nr, nc;
  logic [ROW_W-1:0]     r_q;
  logic [COL_W-1:0]     c_q;
  logic                 inside_q;
  logic                 wr_inside;
  logic [CFG_W-1:0]     r7, c7, rs0, rs2, cs0, cs2, rsel, csel;
  logic [RAW+CAW-1:0]   rd_addr, wr_addr;
  logic                 rdata;
  logic                 rd_pend;
  logic [TAP_IDX_W-1:0] rd_idx_d;
  logic [COUNT_W-1:0]   count;
  logic                 cur;
  logic                 next_alive;

  // Clamp the sizes to the legal range
  always_comb begin
    if (rows_cfg < MIN_SIZE) nr = MIN_SIZE;
    else if (int'(rows_cfg) > MAX_ROWS) nr = CFG_W'(MAX_ROWS);
    else nr = rows_cfg;
    if (cols_cfg < MIN_SIZE) nc = MIN_SIZE;
    else if (int'(cols_cfg) > MAX_COLS) nc = CFG_W'(MAX_COLS);
    else nc = cols_cfg;
  end

  assign wr_inside = ({1'b0, in_data.row} < nr) && ({1'b0, in_data.col} < nc);
  assign wr_addr   = {RAW'(in_data.row), CAW'(in_data.col)};

  // Neighbour indexes with wrap at both edges
  assign r7  = {1'b0, r_q};
  assign c7  = {1'b0, c_q};
  assign rs0 = (r_q == '0) ? nr - 7'd1 : r7 - 7'd1;
  assign rs2 = (r7 + 7'd1 == nr) ? 7'd0 : r7 + 7'd1;
  assign cs0 = (c_q == '0) ? nc - 7'd1 : c7 - 7'd1;
  assign cs2 = (c7 + 7'd1 == nc) ? 7'd0 : c7 + 7'd1;

  always_comb begin
    case (cmd.rd_idx)
      4'd0, 4'd1, 4'd2: rsel = rs0;
      4'd3, 4'd4, 4'd5: rsel = r7;
      default:          rsel = rs2;
    endcase
    case (cmd.rd_idx)
      4'd0, 4'd3, 4'd6: csel = cs0;
      4'd1, 4'd4, 4'd7: csel = c7;
      default:          csel = cs2;
    endcase
  end

  assign rd_addr = {RAW'(rsel), CAW'(csel)};

  // Single port: a write only comes in while no query is reading
  always_ff @(posedge clk) begin
    if (cmd.wr_en && wr_inside) mem[wr_addr] <= in_data.alive_in;
    else if (cmd.rd_en) rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_d <= cmd.rd_idx;
    if (cmd.start) begin
      r_q      <= in_data.row;
      c_q      <= in_data.col;
      inside_q <= wr_inside;
      count    <= '0;
      cur      <= 1'b0;
    end else if (rd_pend) begin
      if (rd_idx_d == TAP_CENTER) cur <= rdata;
      else count <= count + {{(COUNT_W-1){1'b0}}, rdata};
    end
  end

  always_comb begin
    if (cur) next_alive = (count == COUNT_TWO) || (count == COUNT_THREE);
    else next_alive = (count == COUNT_THREE);
  end

  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (inside_q) begin
        out_data.neighbour_count <= count;
        out_data.next_alive      <= next_alive;
        out_data.flips           <= next_alive ^ cur;
      end else begin
        out_data <= '0;
      end
    end
  end

endmodule

@@ rtl/life_cell_next_state_torus.sv @@
// Write item: stored at the edge that accepts it, no result.
// Query item: result after nine single-port grid reads, a drain state and a
// load into the output register, which waits while the output is full; no
// new item is taken until that load. The grid memory gives one read per cycle.
// Reset clears control state and sets both sizes to 64; grid contents stay
// undefined until written.
module life_cell_next_state_torus #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  lcnt_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output lcnt_pkg::out_item_t         out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [lcnt_pkg::CFG_W-1:0]  cfg_data
);
  import lcnt_pkg::*;

  logic [CFG_W-1:0] rows_in_use;
  logic [CFG_W-1:0] cols_in_use;
  cmd_t             cmd;
  stat_t            stat;

  // Configuration is always taken; writes beyond the list are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= 7'd64;
      cols_in_use <= 7'd64;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ROWS: rows_in_use <= cfg_data;
        CFG_COLS: cols_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequence the write or the nine-tap scan of a query
  lcnt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_mode  (in_data.mode),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Hold the grid, form wrapped addresses, count neighbours, hold the result
  lcnt_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .rows_cfg  (rows_in_use),
    .cols_cfg  (cols_in_use),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ verif/life_cell_next_state_torus_test.sv @@
`timescale 1ns / 1ps

module life_cell_next_state_torus_test;
  import lcnt_pkg::*;

  // Largest grid the block is built for, and the upper clamp bound on the sizes
  localparam int GRID_MAX = 64;
  // Quiet cycles after the last result before touching the registers or ending
  localparam int SETTLE_CYCLES = 24;
  // Register indexes that hold no register; writes to them must change nothing
  localparam logic [1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [1:0] CFG_SPARE_HI = 2'd3;
  localparam int RANDOM_PHASES = 9;
  localparam int PHASE_ITEMS = 150;
  // Rows and columns written up front: a low block and a band at the far edge
  localparam int FILL_LO = 16;
  localparam int FILL_HI = 4;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_item_t         in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [1:0]       cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  life_cell_next_state_torus dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Shadow of the grid and of the two size registers
  logic             board [GRID_MAX][GRID_MAX];
  // Cells the block has stored at least once
  bit               written [GRID_MAX][GRID_MAX];
  logic [CFG_W-1:0] rows_reg;
  logic [CFG_W-1:0] cols_reg;
  // Neighbour counts and next states still owed by the block, oldest first
  out_item_t        pending_results [$];
  int               errors = 0;
  // Set to hold both sides busy with no random idle cycles
  bit               steady = 1'b0;

  // Clamp a size register to the range the block actually uses
  function automatic int fold_size(input logic [CFG_W-1:0] value);
    if (value < MIN_SIZE) return MIN_SIZE;
    if (value > GRID_MAX) return GRID_MAX;
    return value;
  endfunction

  function automatic in_item_t make_item(input logic [0:0] mode, input int r, input int c,
                                         input logic alive);
    in_item_t item;
    item.mode     = mode;
    item.row      = ROW_W'(r);
    item.col      = COL_W'(c);
    item.alive_in = alive;
    return item;
  endfunction

  // True when a query of the cell reads only written cells; else name the first gap
  function automatic bit window_written(input int r, input int c, input int nr, input int nc,
                                        output int gap_r, output int gap_c);
    int rs [3];
    int cs [3];
    int i, j;
    gap_r = r;
    gap_c = c;
    if (r >= nr || c >= nc) return 1'b1;
    rs[0] = (r == 0) ? nr - 1 : r - 1;
    rs[1] = r;
    rs[2] = (r + 1 == nr) ? 0 : r + 1;
    cs[0] = (c == 0) ? nc - 1 : c - 1;
    cs[1] = c;
    cs[2] = (c + 1 == nc) ? 0 : c + 1;
    for (i = 0; i < 3; i++) begin
      for (j = 0; j < 3; j++) begin
        if (!written[rs[i]][cs[j]]) begin
          gap_r = rs[i];
          gap_c = cs[j];
          return 1'b0;
        end
      end
    end
    return 1'b1;
  endfunction

  // Apply one accepted item to the shadow grid; a query queues its expected result
  task automatic predict_item(input in_item_t item);
    int        nr, nc, r, c, i, j, count;
    int        rs [3];
    int        cs [3];
    logic      cur;
    out_item_t res;
    nr = fold_size(rows_reg);
    nc = fold_size(cols_reg);
    r = item.row;
    c = item.col;
    if (item.mode == MODE_WRITE) begin
      // a write outside the grid in use is dropped
      if (r < nr && c < nc) begin
        board[r][c]   = item.alive_in;
        written[r][c] = 1'b1;
      end
    end else begin
      res = '0;
      if (r < nr && c < nc) begin
        // wrap both edges at the sizes in use, not at the array bounds
        rs[0] = (r == 0) ? nr - 1 : r - 1;
        rs[1] = r;
        rs[2] = (r + 1 == nr) ? 0 : r + 1;
        cs[0] = (c == 0) ? nc - 1 : c - 1;
        cs[1] = c;
        cs[2] = (c + 1 == nc) ? 0 : c + 1;
        count = 0;
        for (i = 0; i < 3; i++) begin
          for (j = 0; j < 3; j++) begin
            if (!(i == 1 && j == 1)) count += board[rs[i]][cs[j]];
          end
        end
        cur = board[r][c];
        res.neighbour_count = COUNT_W'(count);
        if (cur) res.next_alive = (count == COUNT_TWO || count == COUNT_THREE);
        else res.next_alive = (count == COUNT_THREE);
        res.flips = res.next_alive ^ cur;
      end
      pending_results.push_back(res);
    end
  endtask

  // Receiver: stall at random unless held steady
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 15);
  end

  // Check every accepted result against the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no query waiting: neighbour_count %0d next_alive %0b flips %0b",
               out_data.neighbour_count, out_data.next_alive, out_data.flips);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.neighbour_count !== want.neighbour_count) begin
          $error("neighbour_count: expected %0d, actual %0d",
                 want.neighbour_count, out_data.neighbour_count);
          errors++;
        end
        if (out_data.next_alive !== want.next_alive) begin
          $error("next_alive: expected %0b, actual %0b", want.next_alive, out_data.next_alive);
          errors++;
        end
        if (out_data.flips !== want.flips) begin
          $error("flips: expected %0b, actual %0b", want.flips, out_data.flips);
          errors++;
        end
      end
    end
  end

  // Send one item; call at a rising edge, returns at the edge that accepts it.
  // Valid stays high on return so back-to-back items need no second assignment.
  task automatic send_item(input in_item_t item);
    if (!steady && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (!steady && $urandom_range(99) < 15);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_item(item);
  endtask

  // Drop valid, hold until every owed result is in, then let the block settle
  task automatic wait_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (index)
      CFG_ROWS: rows_reg = value;
      CFG_COLS: cols_reg = value;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_size(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
    wait_results();
    write_reg(CFG_ROWS, rows);
    write_reg(CFG_COLS, cols);
  endtask

  // Write the low block and the far-edge band so small grids and the wrap
  // corners of the full grid are all known. Density varies per row.
  task automatic test_fill_grid();
    int r, c, density;
    for (r = 0; r < GRID_MAX; r++) begin
      if (r >= FILL_LO && r < GRID_MAX - FILL_HI) continue;
      density = $urandom_range(100);
      for (c = 0; c < GRID_MAX; c++) begin
        if (c >= FILL_LO && c < GRID_MAX - FILL_HI) continue;
        send_item(make_item(MODE_WRITE, r, c, $urandom_range(99) < density));
      end
    end
    wait_results();
  endtask

  // Walk the corner cell through the life rules, with its window wrapping both edges
  task automatic test_corner_rules();
    int edge_idx [3];
    int i, j;
    edge_idx[0] = GRID_MAX - 1;
    edge_idx[1] = 0;
    edge_idx[2] = 1;
    for (i = 0; i < 3; i++) begin
      for (j = 0; j < 3; j++) begin
        send_item(make_item(MODE_WRITE, edge_idx[i], edge_idx[j], 1'b0));
      end
    end
    // empty window: stays empty
    send_item(make_item(MODE_QUERY, 0, 0, 1'b0));
    // two neighbours, one across the diagonal wrap: no birth
    send_item(make_item(MODE_WRITE, GRID_MAX - 1, GRID_MAX - 1, 1'b1));
    send_item(make_item(MODE_WRITE, 0, 1, 1'b1));
    send_item(make_item(MODE_QUERY, 0, 0, 1'b1));
    // third neighbour: birth
    send_item(make_item(MODE_WRITE, 1, 0, 1'b1));
    send_item(make_item(MODE_QUERY, 0, 0, 1'b0));
    // live cell on three: survives
    send_item(make_item(MODE_WRITE, 0, 0, 1'b1));
    send_item(make_item(MODE_QUERY, 0, 0, 1'b0));
    // live cell on two: survives
    send_item(make_item(MODE_WRITE, 1, 0, 1'b0));
    send_item(make_item(MODE_QUERY, 0, 0, 1'b1));
    // fill the rest of the window: eight neighbours, dies
    send_item(make_item(MODE_WRITE, 1, 0, 1'b1));
    send_item(make_item(MODE_WRITE, GRID_MAX - 1, 0, 1'b1));
    send_item(make_item(MODE_WRITE, GRID_MAX - 1, 1, 1'b1));
    send_item(make_item(MODE_WRITE, 0, GRID_MAX - 1, 1'b1));
    send_item(make_item(MODE_WRITE, 1, GRID_MAX - 1, 1'b1));
    send_item(make_item(MODE_WRITE, 1, 1, 1'b1));
    send_item(make_item(MODE_QUERY, 0, 0, 1'b0));
    // the other corners see the same window from the far side
    send_item(make_item(MODE_QUERY, GRID_MAX - 1, GRID_MAX - 1, 1'b1));
    send_item(make_item(MODE_QUERY, 0, GRID_MAX - 1, 1'b0));
    send_item(make_item(MODE_QUERY, GRID_MAX - 1, 0, 1'b1));
    wait_results();
  endtask

  // Smallest torus, addresses past the edge, and writes to unused indexes
  task automatic test_size_registers();
    set_size(MIN_SIZE, MIN_SIZE);
    send_item(make_item(MODE_QUERY, 2, 2, 1'b0));
    // outside the grid: the write is dropped and the query reads all zero
    send_item(make_item(MODE_WRITE, 3, 0, 1'b1));
    send_item(make_item(MODE_QUERY, 0, 3, 1'b1));
    send_item(make_item(MODE_QUERY, GRID_MAX - 1, GRID_MAX - 1, 1'b0));
    wait_results();
    write_reg(CFG_SPARE_LO, 7'd5);
    write_reg(CFG_SPARE_HI, '1);
    // sizes must still be three by three
    send_item(make_item(MODE_QUERY, 1, 1, 1'b0));
    send_item(make_item(MODE_QUERY, 2, 0, 1'b1));
    // grow by one: row three must still hold its old value
    set_size(7'd4, 7'd4);
    send_item(make_item(MODE_QUERY, 3, 0, 1'b0));
    send_item(make_item(MODE_QUERY, 0, 0, 1'b1));
    wait_results();
  endtask

  // Random traffic over a spread of grid sizes, out-of-range values among them
  task automatic test_random_traffic();
    int               phase, k, nr, nc, gap_r, gap_c;
    logic [CFG_W-1:0] rsz, csz;
    in_item_t         item;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin rsz = CFG_W'(GRID_MAX); csz = CFG_W'(GRID_MAX); end
        1: begin rsz = MIN_SIZE; csz = MIN_SIZE; end
        2: begin rsz = MIN_SIZE; csz = CFG_W'(GRID_MAX); end
        3: begin rsz = CFG_W'(GRID_MAX); csz = MIN_SIZE; end
        4: begin rsz = 7'd0; csz = 7'd1; end
        5: begin rsz = 7'd2; csz = '1; end
        6: begin rsz = 7'd65; csz = 7'd100; end
        default: begin
          rsz = CFG_W'($urandom_range(MIN_SIZE, FILL_LO));
          csz = CFG_W'($urandom_range(MIN_SIZE, FILL_LO));
          if ($urandom_range(3) == 0) rsz = CFG_W'($urandom_range(127));
        end
      endcase
      set_size(rsz, csz);
      // one long stretch with no idling on either side
      steady = (phase == 7);
      nr = fold_size(rows_reg);
      nc = fold_size(cols_reg);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        item.mode     = 1'($urandom_range(1));
        item.alive_in = 1'($urandom_range(1));
        if ($urandom_range(99) < 85) begin
          item.row = ROW_W'($urandom_range(nr - 1));
          item.col = COL_W'($urandom_range(nc - 1));
        end else begin
          item.row = ROW_W'($urandom_range(GRID_MAX - 1));
          item.col = COL_W'($urandom_range(GRID_MAX - 1));
        end
        // a query that would read an unwritten cell writes that cell instead
        if (item.mode == MODE_QUERY &&
            !window_written(item.row, item.col, nr, nc, gap_r, gap_c)) begin
          item.mode = MODE_WRITE;
          item.row  = ROW_W'(gap_r);
          item.col  = COL_W'(gap_c);
        end
        send_item(item);
        // hold the sender off until the block has drained
        if (k == PHASE_ITEMS / 2 || $urandom_range(99) == 0) wait_results();
      end
    end
    steady = 1'b0;
    wait_results();
  endtask

  initial begin
    rows_reg = CFG_W'(GRID_MAX);
    cols_reg = CFG_W'(GRID_MAX);
    foreach (board[r, c]) board[r][c] = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_fill_grid();
    test_corner_rules();
    test_size_registers();
    test_random_traffic();
    wait_results();
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Stop a hung run well past the slowest correct one
  initial begin
    #(10_000_000);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
